/* hdl/dpp_pkg.sv */
package dpp_pkg;

	// Final status codes of one path string.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_BADCHAR   = 3'd3,
		ST_HARDENED  = 3'd4
	} status_t;

	// Where the parser stands inside the current token.
	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_SAW_M  = 2'd1,
		PH_DIGITS = 2'd2,
		PH_HARD   = 2'd3
	} phase_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned ElemW = 32;
	localparam logic [ElemW-1:0] HARD_BIT = 32'h8000_0000;

	typedef struct packed {
		logic [7:0] character;
		logic       is_last;
		logic       is_empty;
	} in_item_t;

	typedef struct packed {
		logic [ElemW-1:0] element;
		logic             element_valid;
		logic             done_res;
		status_t          status;
	} out_item_t;

	typedef struct packed {
		phase_t           phase;
		logic [ElemW-1:0] acc;
		logic             hard;
		logic             first;
		status_t          err;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_START,
		acc:   '0,
		hard:  1'b0,
		first: 1'b1,
		err:   ST_OK
	};

endpackage

/* hdl/dpp_step.sv */
module dpp_step (
	input  dpp_pkg::parse_state_t cur,
	input  dpp_pkg::in_item_t     item,
	output dpp_pkg::parse_state_t nxt,
	output logic                  produce,
	output dpp_pkg::out_item_t    res
);

	logic                           is_digit;
	logic [3:0]                     digit;
	logic [dpp_pkg::ElemW+3:0]      mac;
	logic                           emit;
	logic [dpp_pkg::ElemW-1:0]      fin;

	assign is_digit = (item.character >= dpp_pkg::CH_ZERO) &&
	                  (item.character <= dpp_pkg::CH_NINE);
	assign digit    = item.character[3:0];

	// Times ten as two shifted copies, plus the new digit.
	assign mac = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} +
	             {{dpp_pkg::ElemW{1'b0}}, digit};

	always_comb begin
		nxt     = cur;
		emit    = 1'b0;
		produce = 1'b0;
		res     = '{element: '0, element_valid: 1'b0, done_res: 1'b0,
		            status: dpp_pkg::ST_OK};

		if (cur.err == dpp_pkg::ST_OK) begin
			unique case (cur.phase)
				dpp_pkg::PH_START: begin
					if (item.character == dpp_pkg::CH_SLASH) begin
						nxt.err = dpp_pkg::ST_MALFORMED;
					end else if (item.character == dpp_pkg::CH_M) begin
						nxt.phase = dpp_pkg::PH_SAW_M;
					end else if (is_digit) begin
						nxt.acc   = {{(dpp_pkg::ElemW-4){1'b0}}, digit};
						nxt.hard  = 1'b0;
						nxt.phase = dpp_pkg::PH_DIGITS;
					end else begin
						nxt.err = dpp_pkg::ST_BADCHAR;
					end
				end
				dpp_pkg::PH_SAW_M: begin
					if (item.character == dpp_pkg::CH_SLASH) begin
						if (cur.first) begin
							nxt.first = 1'b0;
							nxt.phase = dpp_pkg::PH_START;
						end else begin
							nxt.err = dpp_pkg::ST_MALFORMED;
						end
					end else begin
						nxt.err = dpp_pkg::ST_BADCHAR;
					end
				end
				dpp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						if (mac[dpp_pkg::ElemW+3:dpp_pkg::ElemW] != 4'd0) begin
							nxt.err = dpp_pkg::ST_BADCHAR;
						end else begin
							nxt.acc = mac[dpp_pkg::ElemW-1:0];
						end
					end else if (item.character == dpp_pkg::CH_SLASH) begin
						emit      = 1'b1;
						nxt.first = 1'b0;
						nxt.phase = dpp_pkg::PH_START;
					end else if (item.character == dpp_pkg::CH_APOS ||
					             item.character == dpp_pkg::CH_H) begin
						if (cur.acc[dpp_pkg::ElemW-1]) begin
							nxt.err = dpp_pkg::ST_HARDENED;
						end else begin
							nxt.hard  = 1'b1;
							nxt.phase = dpp_pkg::PH_HARD;
						end
					end else begin
						nxt.err = dpp_pkg::ST_BADCHAR;
					end
				end
				dpp_pkg::PH_HARD: begin
					if (item.character == dpp_pkg::CH_SLASH) begin
						emit      = 1'b1;
						nxt.first = 1'b0;
						nxt.phase = dpp_pkg::PH_START;
					end else begin
						nxt.err = dpp_pkg::ST_MALFORMED;
					end
				end
				default: begin
					nxt.err = dpp_pkg::ST_MALFORMED;
				end
			endcase
		end

		// The final character closes whatever token is still open.
		if (item.is_last && nxt.err == dpp_pkg::ST_OK) begin
			if (nxt.phase == dpp_pkg::PH_START) begin
				nxt.err = dpp_pkg::ST_MALFORMED;
			end else if (nxt.phase == dpp_pkg::PH_SAW_M) begin
				if (!nxt.first) begin
					nxt.err = dpp_pkg::ST_MALFORMED;
				end
			end else begin
				emit = 1'b1;
			end
		end

		if (nxt.err != dpp_pkg::ST_OK) begin
			emit = 1'b0;
		end

		fin = nxt.hard ? (nxt.acc | dpp_pkg::HARD_BIT) : nxt.acc;

		if (item.is_empty) begin
			produce = 1'b1;
			res     = '{element: '0, element_valid: 1'b0, done_res: 1'b1,
			            status: dpp_pkg::ST_EMPTY};
			nxt     = dpp_pkg::STATE_RESET;
		end else if (item.is_last) begin
			produce           = 1'b1;
			res.element       = emit ? fin : '0;
			res.element_valid = emit;
			res.done_res      = 1'b1;
			res.status        = nxt.err;
			nxt               = dpp_pkg::STATE_RESET;
		end else if (emit) begin
			produce           = 1'b1;
			res.element       = fin;
			res.element_valid = 1'b1;
		end
	end

endmodule

/* hdl/dpp_out_reg.sv */
module dpp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  dpp_pkg::out_item_t load_data,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output dpp_pkg::out_item_t out_item
);

	logic               valid_q;
	dpp_pkg::out_item_t data_q;

	// A new result may enter when the register is empty or is being drained.
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= load_data;
		end
	end

endmodule

/* hdl/derivation_path_parser_unit.sv */
// Streaming syntax checker for key derivation paths such as m/44'/7'/0h. The
// string arrives one character per input transaction, with is_last on its final
// character, or as a single transaction with is_empty set for a zero-length
// string. Each slash-separated token is an unsigned 32-bit decimal number with
// an optional hardening mark (apostrophe or h) that sets bit 31; a lone m is
// allowed only as the first token. A result transaction is produced when an
// element completes and for the final character, which also carries the status
// (0 ok, 1 empty, 2 malformed, 3 invalid character, 4 already hardened).
// Elements already delivered must be discarded by the consumer when the final
// status is an error. Throughput is one character per clock cycle while no
// result is stalled; the accepted character is held in an input register while
// the combinational per-character update (a times-ten accumulate with overflow
// check) runs, and its result is then registered in the result register, from
// which the consumer takes it. The result register is freed by out_ready alone,
// and in_ready follows out_ready in the same cycle. While a result is stalled,
// the block still takes one more character into its input register and then
// holds in_ready low until the result is taken.
module derivation_path_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dpp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output dpp_pkg::out_item_t out_item
);

	// Input stage: one accepted character waiting for its update.
	logic                  valid_s1;
	dpp_pkg::in_item_t     item_s1;

	// Parser state carried from one character to the next.
	dpp_pkg::parse_state_t state_q;
	dpp_pkg::parse_state_t state_nxt;

	logic                  produce;
	dpp_pkg::out_item_t    res;
	logic                  can_load;
	logic                  advance;

	// The held character is processed when the result register can take its
	// result, whether or not it actually produces one.
	assign advance  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= dpp_pkg::STATE_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	dpp_step u_step (
		.cur     (state_q),
		.item    (item_s1),
		.nxt     (state_nxt),
		.produce (produce),
		.res     (res)
	);

	dpp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && produce),
		.load_data (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// An element is only ever delivered alongside an ok status.
	a_elem_ok : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.element_valid |-> out_item.status == dpp_pkg::ST_OK)
		else $error("element delivered with an error status");

	// Intermediate results carry an element and no status (always ok).
	a_mid_status : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.done_res |-> out_item.status == dpp_pkg::ST_OK &&
		out_item.element_valid)
		else $error("intermediate result without element or with status");

	// The end of a string returns the parser to its start state.
	a_end_reset : assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.is_last || item_s1.is_empty) |=>
		state_q.phase == dpp_pkg::PH_START && state_q.first &&
		state_q.err == dpp_pkg::ST_OK)
		else $error("parser state not cleared after end of string");

	// A stalled result stays in place.
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

endmodule
